// ===== design/lft_pkg.sv =====
// ----------------------------------------------------------------------------
// lft_pkg: shared types and constants for the LRU frame table
// Field widths, the search token that runs along the cell chain, and the
// write-back request that updates one frame.
// ----------------------------------------------------------------------------
package lft_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

  localparam int PID_W   = 16;
  localparam int PAGE_W  = 20;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 7;
  localparam int FIDX_W  = 6;
  localparam int FREED_W = 7;
  localparam int OUTC_W  = 2;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(64);
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [STAMP_W-1:0] STAMP_INIT = STAMP_W'(1);

  localparam logic ACT_TOUCH   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [OUTC_W-1:0] OUTC_HIT      = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_FILL     = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_EVICT    = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_RELEASED = 2'd3;

  typedef logic [PID_W-1:0]   pid_t;
  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Search token: request fields plus the running hit / empty / oldest scan
  typedef struct packed {
    logic   valid;
    logic   release_op;
    pid_t   pid;
    page_t  page;
    logic   hit;
    idx_t   hit_idx;
    logic   have_empty;
    idx_t   empty_idx;
    logic   have_old;
    stamp_t old_stamp;
    idx_t   old_idx;
    pid_t   old_owner;
    page_t  old_page;
    cnt_t   freed;
  } token_t;

  // Frame update broadcast to all cells
  typedef struct packed {
    logic   en;
    logic   stamp_only;
    idx_t   idx;
    pid_t   owner;
    page_t  page;
    stamp_t stamp;
  } wb_t;

endpackage

// ===== design/lft_req_if.sv =====
// ----------------------------------------------------------------------------
// lft_req_if: request channel of the LRU frame table
// Valid/ready handshake carrying a touch or release request.
// ----------------------------------------------------------------------------
interface lft_req_if import lft_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              action;
  logic [PID_W-1:0]  process_id;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output action, output process_id, output page_number,
                  input ready);
  modport sink   (input valid, input action, input process_id, input page_number,
                  output ready);

endinterface

// ===== design/lft_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lft_rsp_if: result channel of the LRU frame table
// Valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface lft_rsp_if import lft_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [OUTC_W-1:0]  outcome;
  logic [FIDX_W-1:0]  frame_index;
  logic [PID_W-1:0]   victim_process;
  logic [PAGE_W-1:0]  victim_page;
  logic [FREED_W-1:0] frames_freed;

  modport source (output valid, output outcome, output frame_index, output victim_process,
                  output victim_page, output frames_freed, input ready);
  modport sink   (input valid, input outcome, input frame_index, input victim_process,
                  input victim_page, input frames_freed, output ready);

endinterface

// ===== design/lft_cell.sv =====
// ----------------------------------------------------------------------------
// lft_cell: one frame of the table
// Holds owner, page and stamp of its frame, folds its entry into the passing
// search token, clears itself on a matching release, and takes write-backs.
// ----------------------------------------------------------------------------
module lft_cell import lft_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  idx_t   idx_i,
  input  cnt_t   active_i,
  input  token_t tok_i,
  input  wb_t    wb_i,
  output token_t tok_o
);

  pid_t   owner_q, owner_d;
  page_t  page_q, page_d;
  stamp_t stamp_q, stamp_d;
  token_t tok_q, tok_d;
  logic   in_range;
  logic   empty;

  assign in_range = CNT_W'(idx_i) < active_i;
  assign empty    = (owner_q == '0);

  always_comb begin
    tok_d   = tok_i;
    owner_d = owner_q;
    page_d  = page_q;
    stamp_d = stamp_q;
    if (tok_i.valid) begin
      if (tok_i.release_op) begin
        if (tok_i.pid != '0 && owner_q == tok_i.pid) begin
          owner_d   = '0;
          tok_d.freed = tok_i.freed + 1'b1;
        end
      end else if (in_range) begin
        if (empty) begin
          if (!tok_i.have_empty) begin
            tok_d.have_empty = 1'b1;
            tok_d.empty_idx  = idx_i;
          end
        end else begin
          if (!tok_i.hit && tok_i.pid != '0 && owner_q == tok_i.pid &&
              page_q == tok_i.page) begin
            tok_d.hit     = 1'b1;
            tok_d.hit_idx = idx_i;
          end
          // strict less-than keeps the lowest index on equal stamps
          if (!tok_i.have_old || stamp_q < tok_i.old_stamp) begin
            tok_d.have_old  = 1'b1;
            tok_d.old_stamp = stamp_q;
            tok_d.old_idx   = idx_i;
            tok_d.old_owner = owner_q;
            tok_d.old_page  = page_q;
          end
        end
      end
    end
    if (wb_i.en && wb_i.idx == idx_i) begin
      stamp_d = wb_i.stamp;
      if (!wb_i.stamp_only) begin
        owner_d = wb_i.owner;
        page_d  = wb_i.page;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
      tok_q   <= '0;
    end else begin
      owner_q <= owner_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q  <= page_d;
    stamp_q <= stamp_d;
  end

  assign tok_o = tok_q;

endmodule

// ===== design/lru_frame_table_unit.sv =====
// ----------------------------------------------------------------------------
// lru_frame_table_unit: fully associative frame table with LRU replacement
//
//   channel   dir  handshake            payload
//   req_i     in   valid/ready          action, process_id, page_number
//   rsp_o     out  valid/ready          outcome, frame_index, victim_*, frames_freed
//   cfg       in   cfg_we_i, no stall   cfg_wdata_i = frames_in_use
//
// One request in flight: a token waits in the input register, then
// walks the chain of NUM_FRAMES cells, one cell per cycle; the result and
// write-back are then registered and the cells apply the write-back, and
// only then, while the output is free, does the next request start.
// Reset empties every frame and sets the stamp counter to one.
// A result waiting on rsp_o does not block the next request; a second
// finished result waits in a holding register, and stalls the input, until
// the output frees up.
// ----------------------------------------------------------------------------
module lru_frame_table_unit import lft_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  lft_req_if.sink          req_i,
  lft_rsp_if.source        rsp_o
);

  logic [CFG_W-1:0] cfg_q;
  cnt_t             active;
  token_t           inj_q, inj_d;
  token_t           tok_w [NUM_FRAMES+1];
  token_t           last;
  wb_t              wb_q, wb_d;
  stamp_t           stamp_q;
  logic             busy_q;
  logic             pend_q;
  logic             accept;
  logic             load_out;

  // result fields: pending and output registers
  logic [OUTC_W-1:0]  res_outc;
  logic [FIDX_W-1:0]  res_fidx;
  pid_t               res_vproc;
  page_t              res_vpage;
  logic [FREED_W-1:0] res_freed;
  logic [OUTC_W-1:0]  pend_outc_q, out_outc_q;
  logic [FIDX_W-1:0]  pend_fidx_q, out_fidx_q;
  pid_t               pend_vproc_q, out_vproc_q;
  page_t              pend_vpage_q, out_vpage_q;
  logic [FREED_W-1:0] pend_freed_q, out_freed_q;
  logic               out_valid_q;

  // zero acts as one frame, anything above the table size as the full table
  always_comb begin
    if (cfg_q == '0) begin
      active = CNT_W'(1);
    end else if (32'(cfg_q) > 32'(NUM_FRAMES)) begin
      active = CNT_W'(NUM_FRAMES);
    end else begin
      active = CNT_W'(cfg_q);
    end
  end

  assign req_i.ready = !busy_q && !pend_q;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    inj_d            = '0;
    inj_d.valid      = accept;
    inj_d.release_op = (req_i.action == ACT_RELEASE);
    inj_d.pid        = req_i.process_id;
    inj_d.page       = req_i.page_number;
  end

  assign tok_w[0] = inj_q;

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    lft_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (IDX_W'(g)),
      .active_i (active),
      .tok_i    (tok_w[g]),
      .wb_i     (wb_q),
      .tok_o    (tok_w[g+1])
    );
  end

  assign last = tok_w[NUM_FRAMES];

  // decision at the end of the chain
  always_comb begin
    res_outc  = OUTC_RELEASED;
    res_fidx  = '0;
    res_vproc = '0;
    res_vpage = '0;
    res_freed = '0;
    wb_d       = '0;
    wb_d.owner = last.pid;
    wb_d.page  = last.page;
    wb_d.stamp = stamp_q;
    if (last.release_op) begin
      res_freed = FREED_W'(last.freed);
    end else begin
      wb_d.en = last.valid;
      if (last.hit) begin
        res_outc        = OUTC_HIT;
        wb_d.idx        = last.hit_idx;
        wb_d.stamp_only = 1'b1;
      end else if (last.have_empty) begin
        res_outc = OUTC_FILL;
        wb_d.idx = last.empty_idx;
      end else begin
        res_outc  = OUTC_EVICT;
        wb_d.idx  = last.old_idx;
        res_vproc = last.old_owner;
        res_vpage = last.old_page;
      end
      res_fidx = FIDX_W'(wb_d.idx);
    end
  end

  assign load_out = pend_q && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      inj_q       <= '0;
      wb_q        <= '0;
      stamp_q     <= STAMP_INIT;
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      inj_q <= inj_d;
      wb_q  <= wb_d;
      if (accept) begin
        busy_q <= 1'b1;
      end
      if (last.valid) begin
        busy_q <= 1'b0;
        pend_q <= 1'b1;
        if (!last.release_op && stamp_q != STAMP_MAX) begin
          stamp_q <= stamp_q + 1'b1;
        end
      end else if (load_out) begin
        pend_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last.valid) begin
      pend_outc_q  <= res_outc;
      pend_fidx_q  <= res_fidx;
      pend_vproc_q <= res_vproc;
      pend_vpage_q <= res_vpage;
      pend_freed_q <= res_freed;
    end
    if (load_out) begin
      out_outc_q  <= pend_outc_q;
      out_fidx_q  <= pend_fidx_q;
      out_vproc_q <= pend_vproc_q;
      out_vpage_q <= pend_vpage_q;
      out_freed_q <= pend_freed_q;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.outcome        = out_outc_q;
  assign rsp_o.frame_index    = out_fidx_q;
  assign rsp_o.victim_process = out_vproc_q;
  assign rsp_o.victim_page    = out_vpage_q;
  assign rsp_o.frames_freed   = out_freed_q;

endmodule

// ===== design/lft_checker.sv =====
// ----------------------------------------------------------------------------
// lft_checker: port-level checks for the LRU frame table
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module lft_checker import lft_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [OUTC_W-1:0]  outcome_i,
  input logic [FIDX_W-1:0]  frame_index_i,
  input logic [PID_W-1:0]   victim_process_i,
  input logic [PAGE_W-1:0]  victim_page_i,
  input logic [FREED_W-1:0] frames_freed_i
);

  // one request at a time: no second accept right behind the first
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another is in flight");

  // a result never shows up the cycle after a request is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !$rose(rsp_valid_i))
    else $error("result appeared too early after a request");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(outcome_i) &&
    $stable(frame_index_i) && $stable(frames_freed_i))
    else $error("stalled result changed");

  a_release_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && outcome_i == OUTC_RELEASED |->
    frame_index_i == '0 && victim_process_i == '0 && victim_page_i == '0)
    else $error("release result carries frame or victim data");

  a_touch_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && outcome_i != OUTC_RELEASED |-> frames_freed_i == '0 &&
    (outcome_i == OUTC_EVICT || (victim_process_i == '0 && victim_page_i == '0)))
    else $error("touch result carries release count or stray victim");

endmodule

bind lru_frame_table_unit lft_checker u_lft_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .outcome_i        (rsp_o.outcome),
  .frame_index_i    (rsp_o.frame_index),
  .victim_process_i (rsp_o.victim_process),
  .victim_page_i    (rsp_o.victim_page),
  .frames_freed_i   (rsp_o.frames_freed)
);
